FILE: design/b64d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

   // Sextet code: bit 6 marks an invalid character, bits 5:0 hold the value.
   localparam int SEXTET_W    = 7;
   localparam int BYTES_PER_GROUP = 3;
   localparam int HELD_COUNT  = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [SEXTET_W-1:0] BAD_SEXTET = 7'h7f;
   localparam int BAD_BIT = 6;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2b;
   localparam logic [7:0] CHAR_MINUS   = 8'h2d;
   localparam logic [7:0] CHAR_SLASH   = 8'h2f;
   localparam logic [7:0] CHAR_UNDER   = 8'h5f;
   localparam logic [7:0] CHAR_LESS    = 8'h3c;

   localparam logic [7:0] LOWER_OFFSET = 8'd26;
   localparam logic [7:0] DIGIT_OFFSET = 8'd52;
   localparam logic [5:0] SEXTET_62    = 6'd62;
   localparam logic [5:0] SEXTET_63    = 6'd63;

   // One closed group as handed from front to back.
   typedef struct packed {
      logic [BYTES_PER_GROUP-1:0][7:0] bytes;
      logic [BYTES_PER_GROUP-1:0]      keep;
      logic                            text_last;
   } b64d_group_type;

   function automatic logic [SEXTET_W-1:0] map_char(input logic [7:0] c);
      logic [7:0] diff;
      logic [SEXTET_W-1:0] s;
      diff = 8'd0;
      s    = BAD_SEXTET;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         diff = c - CHAR_UPPER_A;
         s    = {1'b0, diff[5:0]};
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         diff = c - CHAR_LOWER_A + LOWER_OFFSET;
         s    = {1'b0, diff[5:0]};
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         diff = c - CHAR_DIGIT_0 + DIGIT_OFFSET;
         s    = {1'b0, diff[5:0]};
      end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
         s = {1'b0, SEXTET_62};
      end else if (c == CHAR_SLASH || c == CHAR_UNDER) begin
         s = {1'b0, SEXTET_63};
      end else if (c == CHAR_LESS) begin
         s = {SEXTET_W{1'b0}};
      end
      return s;
   endfunction

endpackage

`default_nettype wire

FILE: design/b64d_front.sv
`timescale 1ns / 1ps
`default_nettype none

module b64d_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [7:0]              req_char_code,
   input  wire logic                    req_end_of_text,
   input  wire logic                    queue_full,
   output logic                         push,
   output b64d_pkg::b64d_group_type     push_group
);
   import b64d_pkg::*;

   logic [1:0]          pos_ff, pos_in;
   logic [SEXTET_W-1:0] held_ff [HELD_COUNT];
   logic [SEXTET_W-1:0] cur;
   logic [SEXTET_W-1:0] s [4];
   logic                accept;
   logic                closes;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign cur       = map_char(req_char_code);
   assign closes    = (pos_ff == 2'd3) || req_end_of_text;

   always_comb begin
      for (int i = 0; i < HELD_COUNT; i++) begin
         if (2'(i) < pos_ff) begin
            s[i] = held_ff[i];
         end else if (2'(i) == pos_ff) begin
            s[i] = cur;
         end else begin
            s[i] = BAD_SEXTET;
         end
      end
      s[3] = (pos_ff == 2'd3) ? cur : BAD_SEXTET;
   end

   always_comb begin
      push_group.bytes[0]  = {s[0][5:0], s[1][5:4]};
      push_group.bytes[1]  = {s[1][3:0], s[2][5:2]};
      push_group.bytes[2]  = {s[2][1:0], s[3][5:0]};
      push_group.keep[0]   = !s[1][BAD_BIT];
      push_group.keep[1]   = !s[2][BAD_BIT];
      push_group.keep[2]   = !s[3][BAD_BIT];
      push_group.text_last = req_end_of_text;
   end

   // groups with no surviving byte are dropped here
   assign push = accept && closes && (push_group.keep != '0);

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         pos_in = closes ? 2'd0 : pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 2'd0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !closes) begin
         held_ff[pos_ff] <= cur;
      end
   end

endmodule

`default_nettype wire

FILE: design/b64d_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module b64d_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire b64d_pkg::b64d_group_type push_group,
   output logic                         full,
   input  wire logic                    pop,
   output logic                         head_valid,
   output b64d_pkg::b64d_group_type     head_group
);
   import b64d_pkg::*;

   b64d_group_type         entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_group = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_group;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !head_valid))
      else $error("queue pop while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || full) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

FILE: design/b64d_back.sv
`timescale 1ns / 1ps
`default_nettype none

module b64d_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    head_valid,
   input  wire b64d_pkg::b64d_group_type head_group,
   output logic                         pop,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [7:0]                   rsp_data_byte,
   output logic                         rsp_group_last,
   output logic                         rsp_text_last
);
   import b64d_pkg::*;

   logic [BYTES_PER_GROUP-1:0][7:0] bytes_ff, bytes_in;
   logic [BYTES_PER_GROUP-1:0]      keep_ff, keep_in;
   logic                            text_ff, text_in;
   logic                            valid_ff, valid_in;
   logic [7:0]                      data_ff, data_in;
   logic                            glast_ff, glast_in;
   logic                            tlast_ff, tlast_in;
   logic                            out_load;
   logic                            advance;
   logic [BYTES_PER_GROUP-1:0]      low_bit;
   logic [BYTES_PER_GROUP-1:0]      remaining;
   logic [7:0]                      sel_byte;

   assign out_load = !valid_ff || !rsp_stall;
   assign advance  = out_load && (keep_ff != '0);
   assign low_bit  = keep_ff & (~keep_ff + 1'b1);
   assign remaining = keep_ff & ~low_bit;

   always_comb begin
      case (1'b1)
         low_bit[0]: sel_byte = bytes_ff[0];
         low_bit[1]: sel_byte = bytes_ff[1];
         default:    sel_byte = bytes_ff[2];
      endcase
   end

   // refill as the last byte of the current group goes out
   assign pop = head_valid && ((keep_ff == '0) || (advance && remaining == '0));

   always_comb begin
      keep_in  = advance ? remaining : keep_ff;
      bytes_in = bytes_ff;
      text_in  = text_ff;
      if (pop) begin
         keep_in  = head_group.keep;
         bytes_in = head_group.bytes;
         text_in  = head_group.text_last;
      end
      valid_in = advance ? 1'b1 : (out_load ? 1'b0 : valid_ff);
      data_in  = advance ? sel_byte : data_ff;
      glast_in = advance ? (remaining == '0) : glast_ff;
      tlast_in = advance ? text_ff : tlast_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         keep_ff  <= keep_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      text_ff  <= text_in;
      data_ff  <= data_in;
      glast_ff <= glast_in;
      tlast_ff <= tlast_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_data_byte  = data_ff;
   assign rsp_group_last = glast_ff;
   assign rsp_text_last  = tlast_ff;

endmodule

`default_nettype wire

FILE: design/base64_tolerant_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake             Payload
// req_      in   req_valid/req_stall   req_char_code[7:0], req_end_of_text
// rsp_      out  rsp_valid/rsp_stall   rsp_data_byte[7:0], rsp_group_last, rsp_text_last
//
// One character per unstalled cycle; a group's bytes leave one per unstalled cycle.
// A closed group passes the queue and the back's group register to the output register.
// Synchronous active-high reset clears group position, queue and output valid.
// req_stall rises only while the 4-entry group queue is full; rsp_stall
// backs up through the output register into that queue.

module base64_tolerant_decoder (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_char_code,
   input  wire logic       req_end_of_text,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_data_byte,
   output logic            rsp_group_last,
   output logic            rsp_text_last
);
   import b64d_pkg::*;

   logic           push;
   b64d_group_type push_group;
   logic           queue_full;
   logic           pop;
   logic           head_valid;
   b64d_group_type head_group;

   // front: character lookup, sextet gathering, byte forming per closed group
   b64d_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_code   (req_char_code),
      .req_end_of_text (req_end_of_text),
      .queue_full      (queue_full),
      .push            (push),
      .push_group      (push_group)
   );

   // decouples request intake from byte delivery
   b64d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_group (head_group)
   );

   // back: walks kept bytes of each group into the output register
   b64d_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_group     (head_group),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_group_last (rsp_group_last),
      .rsp_text_last  (rsp_text_last)
   );

endmodule

`default_nettype wire

FILE: bench/tb_base64_tolerant_decoder.sv
`timescale 1ns / 1ps

// Bench for the base64 decoder: a short table of hand-picked characters, then
// random text streams, scored against an in-bench decoder or typed table bytes.
module tb_base64_tolerant_decoder;

   // Marker for a character outside the alphabet: flag bit 6, value bits all set.
   localparam logic [6:0] INVALID_SEXTET = 7'h7f;
   localparam int IDLE_PCT       = 33;
   localparam int HOLD_CYCLES    = 120;   // long receiver hold-off
   localparam int WATCHDOG_LIMIT = 1000;  // cycles with no handshake at all
   localparam int DRAIN_CYCLES   = 20;    // quiet time after the last byte
   localparam int MAX_REPORTS    = 10;
   localparam int NUM_ROWS       = 26;

   // One decoded byte as it should leave the rsp_ channel.
   typedef struct packed {
      logic [7:0] data;
      logic       grp_last;
      logic       txt_last;
   } decoded_byte_type;

   // One request of the directed table. Where typed is set, cnt bytes b0..b2
   // are the bytes this character must release; group_last falls on the last
   // of them and text_last follows eot.
   typedef struct packed {
      logic [7:0] ch;
      logic       eot;
      logic       typed;
      logic [1:0] cnt;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
   } stim_row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_char_code;
   logic       req_end_of_text;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_data_byte;
   logic       rsp_group_last;
   logic       rsp_text_last;

   // Decoder state kept by the bench.
   logic [1:0] grp_pos;
   logic [6:0] held_sextet [3];

   decoded_byte_type pending_bytes [$];
   int  mismatch_count;
   int  sent;
   bit  quiet;          // no idling on either side while set
   bit  hold_off_req;   // asks the receiver for one long hold-off

   stim_row_type directed_rows [NUM_ROWS] = '{
      // "TWFu" right after reset decodes to "Man"
      '{"T", 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
      '{"W", 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
      '{"F", 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
      '{"u", 1'b0, 1'b1, 2'd3, 8'h4d, 8'h61, 8'h6e},
      // both spellings of 63 and '<' as zero
      '{"/", 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
      '{"_", 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
      '{"<", 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
      '{"/", 1'b0, 1'b1, 2'd3, 8'hff, 8'hf0, 8'h3f},
      // lone final character: nothing comes out
      '{"Q", 1'b1, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
      // two-character final group: one byte
      '{"Q", 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
      '{"Q", 1'b1, 1'b1, 2'd1, 8'h41, 8'h00, 8'h00},
      // top code as leading character: its masked bits still count
      '{8'hff, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
      '{"A", 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
      '{"A", 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
      '{"A", 1'b0, 1'b1, 2'd3, 8'hfc, 8'h00, 8'h00},
      // invalid second character: first byte dropped, later ones kept
      '{"A", 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
      '{8'h80, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
      '{"A", 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
      '{"A", 1'b0, 1'b1, 2'd2, 8'hf0, 8'h00, 8'h00},
      // three-character final group closed by the code just above 'z'
      '{"A", 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
      '{"Q", 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
      '{"{", 1'b1, 1'b1, 2'd1, 8'h01, 8'h00, 8'h00},
      // full group closed by end of text, remaining alphabet edges
      '{"z", 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
      '{"9", 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
      '{"+", 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
      '{"-", 1'b1, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00}
   };

   base64_tolerant_decoder u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_code   (req_char_code),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_group_last  (rsp_group_last),
      .rsp_text_last   (rsp_text_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Alphabet lookup: bit 6 set means the code is not part of the alphabet.
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c >= "A" && c <= "Z") begin
         v = c - "A";
      end else if (c >= "a" && c <= "z") begin
         v = c - "a" + 8'd26;
      end else if (c >= "0" && c <= "9") begin
         v = c - "0" + 8'd52;
      end else if (c == "+" || c == "-") begin
         v = 8'd62;
      end else if (c == "/" || c == "_") begin
         v = 8'd63;
      end else if (c != "<") begin
         return INVALID_SEXTET;
      end
      return {1'b0, v[5:0]};
   endfunction

   // Takes one accepted character; hands back the bytes it releases, if any.
   task automatic decode_char(input logic [7:0] ch, input logic eot,
                              output decoded_byte_type outb [3], output int n);
      logic [6:0] cur;
      logic [6:0] s [4];
      logic [7:0] b [3];
      logic [2:0] keep;
      int last_i;
      cur    = sextet_of(ch);
      n      = 0;
      last_i = -1;
      // group still open: just remember the sextet
      if (grp_pos < 2'd3 && !eot) begin
         held_sextet[grp_pos] = cur;
         grp_pos = grp_pos + 2'd1;
         return;
      end
      // positions past the closing character count as invalid
      for (int i = 0; i < 3; i++) begin
         if (i < grp_pos)       s[i] = held_sextet[i];
         else if (i == grp_pos) s[i] = cur;
         else                   s[i] = INVALID_SEXTET;
      end
      s[3] = (grp_pos == 2'd3) ? cur : INVALID_SEXTET;
      b[0] = {s[0][5:0], s[1][5:4]};
      b[1] = {s[1][3:0], s[2][5:2]};
      b[2] = {s[2][1:0], s[3][5:0]};
      // each byte is gated only by the validity of its trailing sextet
      for (int i = 0; i < 3; i++) begin
         keep[i] = !s[i+1][6];
         if (keep[i]) last_i = i;
      end
      for (int i = 0; i < 3; i++) begin
         if (keep[i]) begin
            outb[n] = '{data: b[i], grp_last: (i == last_i), txt_last: eot};
            n++;
         end
      end
      grp_pos = 2'd0;
   endtask

   // Offers one request, holding it until taken, then books its bytes.
   task automatic send_char(input stim_row_type row);
      decoded_byte_type got [3];
      logic [7:0] typed_b [3];
      int n;
      while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_char_code   <= row.ch;
      req_end_of_text <= row.eot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_char(row.ch, row.eot, got, n);
      if (row.typed) begin
         // table rows with hand-written bytes replace the decoder's output
         typed_b[0] = row.b0;
         typed_b[1] = row.b1;
         typed_b[2] = row.b2;
         for (int i = 0; i < row.cnt; i++)
            pending_bytes.push_back('{data: typed_b[i], grp_last: (i == row.cnt - 1),
                                      txt_last: row.eot});
      end else begin
         for (int i = 0; i < n; i++) pending_bytes.push_back(got[i]);
      end
   endtask

   // Mostly alphabet characters, with a tenth of raw codes as noise.
   function automatic logic [7:0] rand_text_char();
      logic [7:0] c;
      int k;
      if ($urandom_range(0, 99) < 10) begin
         c = 8'($urandom_range(0, 255));
         return c;
      end
      k = $urandom_range(0, 66);
      c = 8'(k);
      if (k < 26)       c = c + "A";
      else if (k < 52)  c = c - 8'd26 + "a";
      else if (k < 62)  c = c - 8'd52 + "0";
      else if (k == 62) c = "+";
      else if (k == 63) c = "-";
      else if (k == 64) c = "/";
      else if (k == 65) c = "_";
      else              c = "<";
      return c;
   endfunction

   // One text: random length, usually closed by end_of_text.
   task automatic send_text();
      stim_row_type row;
      int len;
      bit closed;
      len    = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 40);
      closed = ($urandom_range(0, 99) < 90);
      for (int i = 0; i < len; i++) begin
         row       = '0;
         row.ch    = rand_text_char();
         row.eot   = closed && (i == len - 1);
         row.typed = 1'b0;
         send_char(row);
         sent++;
      end
   endtask

   // Receiver: random stall, one long hold-off on request, none while quiet.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // Scoreboard: every byte taken is matched against the oldest one booked.
   always @(posedge clock) begin
      decoded_byte_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_bytes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected byte %02h group_last %0b text_last %0b",
                        rsp_data_byte, rsp_group_last, rsp_text_last);
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_data_byte !== want.data || rsp_group_last !== want.grp_last ||
                rsp_text_last !== want.txt_last) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("byte mismatch: expected %02h/%0b/%0b got %02h/%0b/%0b",
                           want.data, want.grp_last, want.txt_last,
                           rsp_data_byte, rsp_group_last, rsp_text_last);
            end
         end
      end
   end

   // Watchdog: too long without a handshake on either channel ends the run.
   initial begin
      int idle_run;
      idle_run = 0;
      while (idle_run < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_run = 0;
         else idle_run++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin
      mismatch_count = 0;
      sent           = 0;
      quiet          = 1'b0;
      hold_off_req   = 1'b0;
      grp_pos        = 2'd0;
      for (int i = 0; i < 3; i++) held_sextet[i] = 7'd0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_char_code   <= 8'h00;
      req_end_of_text <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int r = 0; r < NUM_ROWS; r++) send_char(directed_rows[r]);

      // random text with idling on both sides
      while (sent < 130) send_text();

      // receiver holds off for a long stretch while requests keep coming,
      // so the group queue fills and req_stall rises
      hold_off_req = 1'b1;
      while (sent < 200) send_text();

      // sender pauses until every booked byte is out
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_bytes.size() != 0);

      // back-to-back stretch: no idling anywhere
      quiet = 1'b1;
      while (sent < 320) send_text();
      quiet = 1'b0;

      while (sent < 394) send_text();

      req_valid <= 1'b0;
      do @(posedge clock); while (pending_bytes.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: files.f
design/b64d_pkg.sv
design/b64d_front.sv
design/b64d_queue.sv
design/b64d_back.sv
design/base64_tolerant_decoder.sv
bench/tb_base64_tolerant_decoder.sv
